>>> design/lfhs_pkg.sv
// Shared types, tables and helper functions for the LED fade and haptic sequencer.
`default_nettype none
package lfhs_pkg;

  localparam int unsigned LED_LAST   = 49;
  localparam int unsigned MOTOR_LAST = 14;
  localparam int unsigned LEVEL_W    = 20;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd75;
  localparam logic [4:0]  LEVEL_SCALE = 5'd10;

  typedef logic [1:0] op_t;
  localparam op_t OP_TICK  = 2'd0;
  localparam op_t OP_VALUE = 2'd1;
  localparam op_t OP_FADE  = 2'd2;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  sample;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic       press_event;
    logic       led_write;
    logic [7:0] led_level;
    logic       motor_write;
    logic [7:0] motor_level;
  } result_t;

  localparam logic [7:0] BRIGHT_TAB [LED_LAST+1] = '{
    8'd255, 8'd254, 8'd252, 8'd250, 8'd247, 8'd244, 8'd240, 8'd236, 8'd232, 8'd227,
    8'd221, 8'd216, 8'd213, 8'd210, 8'd203, 8'd197, 8'd190, 8'd182, 8'd175, 8'd168,
    8'd160, 8'd152, 8'd144, 8'd136, 8'd128, 8'd120, 8'd112, 8'd104, 8'd96,  8'd91,
    8'd88,  8'd81,  8'd74,  8'd66,  8'd59,  8'd53,  8'd46,  8'd40,  8'd35,  8'd29,
    8'd24,  8'd20,  8'd16,  8'd12,  8'd9,   8'd6,   8'd4,   8'd2,   8'd1,   8'd0
  };

  localparam logic [7:0] BUZZ_TAB [MOTOR_LAST+1] = '{
    8'd0, 8'd255, 8'd125, 8'd75, 8'd0, 8'd175, 8'd125, 8'd75,
    8'd0, 8'd125, 8'd65,  8'd0,  8'd65, 8'd35, 8'd0
  };

  // Out-of-range steps read the last entry.
  function automatic logic [7:0] bright_at(input logic [5:0] idx);
    logic [7:0] lvl;
    if (idx > 6'(LED_LAST)) lvl = BRIGHT_TAB[LED_LAST];
    else                    lvl = BRIGHT_TAB[idx];
    return lvl;
  endfunction

  function automatic logic [7:0] buzz_at(input logic [3:0] idx);
    logic [7:0] lvl;
    if (idx > 4'(MOTOR_LAST)) lvl = BUZZ_TAB[MOTOR_LAST];
    else                      lvl = BUZZ_TAB[idx];
    return lvl;
  endfunction

  // First index whose scaled entry fits under the level; the last index if none.
  function automatic logic [5:0] target_of(input logic [LEVEL_W-1:0] lvl);
    logic [5:0] t;
    t = 6'(LED_LAST);
    for (int i = LED_LAST - 1; i >= 0; i--) begin
      if (LEVEL_W'(BRIGHT_TAB[i]) * LEVEL_W'(LEVEL_SCALE) <= lvl) t = 6'(i);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

>>> design/lfhs_seq.sv
// Sequencer state and per-transaction datapath: press detect, LED and motor players, level.
`default_nettype none
module lfhs_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [7:0]      cfg_wdata,
  input  wire logic            fire,
  input  wire lfhs_pkg::item_t item,
  output lfhs_pkg::result_t    result
);

  logic [7:0]                      threshold_r;
  logic                            press_active_r, press_active_nxt;
  logic                            led_running_r, led_running_nxt;
  logic [5:0]                      led_step_r, led_step_nxt;
  logic [5:0]                      fade_target_r, fade_target_nxt;
  logic                            motor_running_r, motor_running_nxt;
  logic [3:0]                      motor_step_r, motor_step_nxt;
  logic [lfhs_pkg::LEVEL_W-1:0]    level_r, level_nxt;
  logic [lfhs_pkg::LEVEL_W:0]      level_sum;
  logic [lfhs_pkg::LEVEL_W-1:0]    level_sat;

  assign level_sum = {1'b0, level_r} + (lfhs_pkg::LEVEL_W + 1)'(item.value);
  assign level_sat = level_sum[lfhs_pkg::LEVEL_W] ? '1 : level_sum[lfhs_pkg::LEVEL_W-1:0];

  always_comb begin
    press_active_nxt  = press_active_r;
    led_running_nxt   = led_running_r;
    led_step_nxt      = led_step_r;
    fade_target_nxt   = fade_target_r;
    motor_running_nxt = motor_running_r;
    motor_step_nxt    = motor_step_r;
    level_nxt         = level_r;
    result            = '0;
    unique case (item.operation)
      lfhs_pkg::OP_TICK: begin
        if (item.sample < threshold_r) begin
          if (!press_active_r) begin
            press_active_nxt   = 1'b1;
            result.press_event = 1'b1;
          end
        end else begin
          press_active_nxt = 1'b0;
        end
        if (led_running_r) begin
          result.led_level = lfhs_pkg::bright_at(led_step_r);
          result.led_write = 1'b1;
          if (led_step_r < fade_target_r) begin
            led_step_nxt = led_step_r + 6'd1;
          end else begin
            led_step_nxt    = '0;
            led_running_nxt = 1'b0;
          end
        end
        if (motor_running_r) begin
          result.motor_level = lfhs_pkg::buzz_at(motor_step_r);
          result.motor_write = 1'b1;
          if (motor_step_r < 4'(lfhs_pkg::MOTOR_LAST)) begin
            motor_step_nxt = motor_step_r + 4'd1;
          end else begin
            motor_step_nxt    = '0;
            motor_running_nxt = 1'b0;
          end
        end
      end
      lfhs_pkg::OP_VALUE: begin
        level_nxt         = level_sat;
        fade_target_nxt   = lfhs_pkg::target_of(level_sat);
        led_running_nxt   = 1'b1;
        motor_running_nxt = 1'b1;
      end
      lfhs_pkg::OP_FADE: begin
        led_step_nxt      = fade_target_r;
        fade_target_nxt   = 6'(lfhs_pkg::LED_LAST);
        level_nxt         = '0;
        led_running_nxt   = 1'b1;
        motor_running_nxt = 1'b1;
      end
      default: begin
        // unused code: hold all state, all-zero result
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r     <= lfhs_pkg::THRESHOLD_RESET;
      press_active_r  <= 1'b0;
      led_running_r   <= 1'b0;
      led_step_r      <= '0;
      fade_target_r   <= '0;
      motor_running_r <= 1'b0;
      motor_step_r    <= '0;
      level_r         <= '0;
    end else begin
      if (cfg_we) threshold_r <= cfg_wdata;
      if (fire) begin
        press_active_r  <= press_active_nxt;
        led_running_r   <= led_running_nxt;
        led_step_r      <= led_step_nxt;
        fade_target_r   <= fade_target_nxt;
        motor_running_r <= motor_running_nxt;
        motor_step_r    <= motor_step_nxt;
        level_r         <= level_nxt;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/led_fade_and_haptic_sequencer_top.sv
// Top level of the LED fade and haptic sequencer: input register, sequencer, result register.
//
// Each input transaction (tick, value message or fade-out command) yields exactly one
// result transaction. The block sustains one transaction per clock while out_tready is
// high: an item is captured in an input register, processed combinationally by the
// sequencer and written to a result register once that register is empty or being taken.
// in_tready drops only while both registers are full and the result is not being taken.
// The press threshold is written through cfg_we/cfg_wdata (reset value 75); the user must
// write it only while idle, as the block does not enforce it.
`default_nettype none
module led_fade_and_haptic_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,   // press_threshold
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,    // [7:0] sample, [23:8] value
  input  wire logic [1:0]  in_tuser,    // [1:0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // [0] press_event, [8:1] led_level, [16:9] motor_level
  output logic [1:0]       out_tuser    // [0] led_write, [1] motor_write
);

  logic              in_valid_r;
  lfhs_pkg::item_t   in_item_r;
  logic              out_valid_r;
  lfhs_pkg::result_t out_res_r;
  lfhs_pkg::result_t seq_res;
  logic              advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  lfhs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (advance),
    .item      (in_item_r),
    .result    (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.operation <= in_tuser;
      in_item_r.sample    <= in_tdata[7:0];
      in_item_r.value     <= in_tdata[23:8];
    end
    if (advance) out_res_r <= seq_res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.motor_level, out_res_r.led_level, out_res_r.press_event};
  assign out_tuser  = {out_res_r.motor_write, out_res_r.led_write};

endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for led_fade_and_haptic_sequencer_top: streamed items, model, checks.
`timescale 1ns / 100ps

module tb;

  localparam lfhs_pkg::op_t OP_UNUSED = 2'd3;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  LONG_HOLD = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = 24'd0;
  logic [1:0]  in_tuser = 2'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  led_fade_and_haptic_sequencer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // Sequencer state as the testbench predicts it
  logic [7:0]  m_thr = lfhs_pkg::THRESHOLD_RESET;
  logic        m_pressed = 1'b0;
  logic        m_led_on = 1'b0;
  logic [5:0]  m_led_idx = 6'd0;
  logic [5:0]  m_target = 6'd0;
  logic        m_buzz_on = 1'b0;
  logic [3:0]  m_buzz_idx = 4'd0;
  logic [19:0] m_level = 20'd0;

  lfhs_pkg::item_t   pending_items[$];
  lfhs_pkg::result_t expected_results[$];
  lfhs_pkg::item_t   drv_item;
  lfhs_pkg::result_t drv_pred;
  lfhs_pkg::result_t mon_exp;
  int      gap_left = 0;
  int      rx_wait = 0;
  bit      no_idle = 1'b0;
  bit      stall_req = 1'b0;
  bit      stall_done = 1'b0;
  int      queued_count = 0;
  int      error_count = 0;
  int      cycle_count = 0;

  task automatic step_sequencer_model(input lfhs_pkg::item_t it, output lfhs_pkg::result_t r);
    logic [20:0] sum;
    int idx;
    r = '0;
    case (it.operation)
      lfhs_pkg::OP_TICK: begin
        if (it.sample < m_thr) begin
          if (!m_pressed) begin
            m_pressed = 1'b1;
            r.press_event = 1'b1;
          end
        end else begin
          m_pressed = 1'b0;
        end
        if (m_led_on) begin
          idx = (m_led_idx > lfhs_pkg::LED_LAST) ? lfhs_pkg::LED_LAST : m_led_idx;
          r.led_write = 1'b1;
          r.led_level = lfhs_pkg::BRIGHT_TAB[idx];
          if (m_led_idx < m_target) begin
            m_led_idx = m_led_idx + 6'd1;
          end else begin
            m_led_idx = 6'd0;
            m_led_on = 1'b0;
          end
        end
        if (m_buzz_on) begin
          idx = (m_buzz_idx > lfhs_pkg::MOTOR_LAST) ? lfhs_pkg::MOTOR_LAST : m_buzz_idx;
          r.motor_write = 1'b1;
          r.motor_level = lfhs_pkg::BUZZ_TAB[idx];
          if (m_buzz_idx < lfhs_pkg::MOTOR_LAST) begin
            m_buzz_idx = m_buzz_idx + 4'd1;
          end else begin
            m_buzz_idx = 4'd0;
            m_buzz_on = 1'b0;
          end
        end
      end
      lfhs_pkg::OP_VALUE: begin
        sum = {1'b0, m_level} + 21'(it.value);
        m_level = (sum > 21'hFFFFF) ? 20'hFFFFF : sum[19:0];
        // first entry whose brightness in tenths fits under the level
        idx = 0;
        while (idx < lfhs_pkg::LED_LAST && lfhs_pkg::BRIGHT_TAB[idx] * 10 > m_level) idx++;
        m_target = 6'(idx);
        m_led_on = 1'b1;
        m_buzz_on = 1'b1;
      end
      lfhs_pkg::OP_FADE: begin
        m_led_idx = m_target;
        m_target = 6'(lfhs_pkg::LED_LAST);
        m_level = 20'd0;
        m_led_on = 1'b1;
        m_buzz_on = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  // Driver: offer pending items, predict each transaction as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        step_sequencer_model(drv_item, drv_pred);
        expected_results.push_back(drv_pred);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          drv_item = pending_items.pop_front();
          in_tdata <= {drv_item.value, drv_item.sample};
          in_tuser <= drv_item.operation;
          in_tvalid <= 1'b1;
          gap_left <= draw_wait();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      error_count++;
    end
  endtask

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no prediction pending");
          error_count++;
        end else begin
          mon_exp = expected_results.pop_front();
          check_field("press_event", mon_exp.press_event, out_tdata[0]);
          check_field("led_write", mon_exp.led_write, out_tuser[0]);
          check_field("led_level", mon_exp.led_level, out_tdata[8:1]);
          check_field("motor_write", mon_exp.motor_write, out_tuser[1]);
          check_field("motor_level", mon_exp.motor_level, out_tdata[16:9]);
        end
        rx_wait = draw_wait();
      end
      if (stall_req && !stall_done) begin
        stall_done = 1'b1;
        rx_wait = LONG_HOLD;
      end
      if (rx_wait != 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("led_fade_and_haptic_sequencer_top regression: fail");
      $finish;
    end
  end

  task automatic queue_item(input lfhs_pkg::op_t op, input logic [7:0] s,
                            input logic [15:0] v);
    lfhs_pkg::item_t it;
    it.operation = op;
    it.sample = s;
    it.value = v;
    pending_items.push_back(it);
    if (op != OP_UNUSED) queued_count++;
  endtask

  function automatic logic [7:0] pick_sample();
    int s;
    if ($urandom_range(0, 2) == 0) begin
      s = $urandom_range(0, 255);
    end else begin
      // stay close to the threshold so presses and releases alternate
      s = int'(m_thr) + $urandom_range(0, 6) - 3;
      if (s < 0) s = 0;
      if (s > 255) s = 255;
    end
    return 8'(s);
  endfunction

  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'($urandom_range(0, 300));
      1: v = 16'($urandom_range(0, 2600));
      2: v = 16'($urandom);
      default: v = 16'($urandom_range(2400, 2600));
    endcase
    return v;
  endfunction

  task automatic queue_ticks(input int n);
    for (int i = 0; i < n; i++) queue_item(lfhs_pkg::OP_TICK, pick_sample(), 16'($urandom));
  endtask

  task automatic queue_segment();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      queue_item(lfhs_pkg::OP_VALUE, 8'($urandom), pick_value());
      queue_ticks($urandom_range(0, 60));
    end else if (kind <= 5) begin
      queue_item(lfhs_pkg::OP_FADE, 8'($urandom), 16'($urandom));
      queue_ticks($urandom_range(0, 60));
    end else if (kind == 6) begin
      // drive the level up toward saturation
      n = $urandom_range(15, 20);
      for (int i = 0; i < n; i++)
        queue_item(lfhs_pkg::OP_VALUE, 8'($urandom), 16'($urandom_range(40000, 65535)));
      queue_ticks($urandom_range(0, 20));
    end else if (kind <= 8) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++)
        queue_item(lfhs_pkg::op_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
    end else begin
      queue_ticks($urandom_range(1, 30));
    end
  endtask

  task automatic queue_directed();
    queue_item(lfhs_pkg::OP_TICK, 8'd0, 16'd0);        // press with both players idle
    queue_item(lfhs_pkg::OP_TICK, 8'd0, 16'd0);        // held, no new press
    queue_item(lfhs_pkg::OP_TICK, 8'd75, 16'd0);       // equal to threshold releases
    queue_item(lfhs_pkg::OP_TICK, 8'd74, 16'd0);
    queue_item(lfhs_pkg::OP_TICK, 8'd255, 16'hFFFF);
    queue_item(OP_UNUSED, 8'd255, 16'hFFFF);
    queue_item(lfhs_pkg::OP_VALUE, 8'd0, 16'd0);       // no entry fits: target the last one
    queue_ticks(3);
    queue_item(lfhs_pkg::OP_VALUE, 8'd0, 16'hFFFF);    // target drops below the running step
    queue_item(lfhs_pkg::OP_TICK, 8'd0, 16'd0);
    queue_item(lfhs_pkg::OP_TICK, 8'd0, 16'd0);
    queue_item(lfhs_pkg::OP_FADE, 8'hAA, 16'h5555);
    queue_item(lfhs_pkg::OP_TICK, 8'd255, 16'd0);
    queue_item(lfhs_pkg::OP_TICK, 8'd255, 16'd0);
    queue_item(lfhs_pkg::OP_VALUE, 8'hFF, 16'd1);
    queue_item(lfhs_pkg::OP_TICK, 8'd76, 16'd0);
    queue_item(lfhs_pkg::OP_FADE, 8'd0, 16'd0);
    queue_item(lfhs_pkg::OP_TICK, 8'd1, 16'd0);
    queue_item(lfhs_pkg::OP_TICK, 8'd200, 16'd0);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int thr_plan[6];
    int limit;
    logic [7:0] thr;
    thr_plan = '{75, 0, 255, 1, 254, -1};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        // write the threshold only once the block has gone quiet
        wait_drained();
        thr = (thr_plan[ph] < 0) ? 8'($urandom) : 8'(thr_plan[ph]);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= thr;
        m_thr = thr;
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      @(negedge clk);
      no_idle = (ph == 2 || ph == 4);
      if (ph == 2) stall_req = 1'b1;
      if (ph == 0) queue_directed();
      limit = queued_count + 190;
      while (queued_count < limit) begin
        queue_segment();
        // hold the sender until everything in flight has come back
        if (ph == 3 && queued_count > limit - 95 && queued_count < limit - 60) wait_drained();
      end
    end
    wait_drained();
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("led_fade_and_haptic_sequencer_top regression: pass");
    end else begin
      $display("led_fade_and_haptic_sequencer_top regression: fail");
    end
    $finish;
  end

endmodule
